// File: design/dbss_pkg.sv
// Shared types and constants for the debounced beam speed sensor core.
// No dependencies; every other design file imports this package.

package dbss_pkg;

    // sensor count limits
    localparam int SENSORS_MAX = 4;
    localparam int SENSORS_DEF = 4;
    localparam int IDX_W       = 2;

    // configuration port
    localparam int          CFG_W       = 10;
    localparam int          CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX      = 2'd1;
    localparam logic [7:0]  DEB_RESET   = 8'd20;
    localparam logic [9:0]  BOX_RESET   = 10'd100;

    // timing and speed arithmetic
    localparam logic [15:0] BLOCK_LIMIT = 16'd60000;
    localparam logic [9:0]  MS_PER_S    = 10'd1000;
    localparam logic [15:0] SPEED_MAX   = 16'hFFFF;
    localparam int          NUM_W       = 20;
    localparam int          STEP_W      = 5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // one classified tick, as handed from front to back
    typedef struct packed {
        logic [SENSORS_MAX-1:0]       det;
        logic [SENSORS_MAX-1:0]       rise;
        logic [SENSORS_MAX-1:0]       fall;
        logic [SENSORS_MAX-1:0][15:0] ticks;
    } dbss_rec_t;

    // a record beat with its valid
    typedef struct packed {
        logic      valid;
        dbss_rec_t rec;
    } dbss_beat_t;

endpackage

// File: design/dbss_front.sv
// Front part: accepts ticks, debounces each sensor and tracks blocked time.
// Depends on dbss_pkg; feeds classified records into dbss_fifo.

module dbss_front
    import dbss_pkg::*;
#(
    parameter int SENSORS = SENSORS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SENSORS_MAX-1:0] pin_levels,
    input  logic [7:0]             debounce_ticks,
    input  logic                   full,
    output dbss_beat_t             push
);

    logic [SENSORS-1:0]       stable_reg, stable_next;
    logic [SENSORS-1:0]       prev_reg, prev_next;
    logic [SENSORS-1:0][7:0]  hold_reg, hold_next;
    logic [SENSORS-1:0][15:0] blocked_reg, blocked_next;
    logic [SENSORS_MAX-1:0]   raw_vec;
    dbss_rec_t                rec;
    logic                     accept;

    // presence is the inverted pin level
    assign raw_vec  = ~pin_levels;
    assign in_ready = ~full;
    assign accept   = in_valid & in_ready;

    // per-sensor debounce, edge detect and blocked-time count
    always_comb
    begin
        stable_next  = stable_reg;
        prev_next    = prev_reg;
        hold_next    = hold_reg;
        blocked_next = blocked_reg;
        rec          = '0;
        for (int i = 0; i < SENSORS; i++)
        begin
            if (raw_vec[i] == prev_reg[i])
            begin
                if (hold_reg[i] < debounce_ticks)
                begin
                    hold_next[i] = hold_reg[i] + 8'd1;
                end
                else if (stable_reg[i] != raw_vec[i])
                begin
                    stable_next[i] = raw_vec[i];
                    if (raw_vec[i])
                    begin
                        rec.rise[i]     = 1'b1;
                        blocked_next[i] = '0;
                    end
                    else
                    begin
                        rec.fall[i]  = 1'b1;
                        rec.ticks[i] = blocked_reg[i];
                    end
                end
            end
            else
            begin
                prev_next[i] = raw_vec[i];
                hold_next[i] = '0;
            end
            if (stable_next[i])
            begin
                if (blocked_next[i] < BLOCK_LIMIT)
                begin
                    blocked_next[i] = blocked_next[i] + 16'd1;
                end
                rec.det[i] = 1'b1;
            end
        end
    end

    // sensor state advances only on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg  <= '0;
            prev_reg    <= '0;
            hold_reg    <= '0;
            blocked_reg <= '0;
        end
        else if (accept)
        begin
            stable_reg  <= stable_next;
            prev_reg    <= prev_next;
            hold_reg    <= hold_next;
            blocked_reg <= blocked_next;
        end
    end

    // record beat into the queue
    assign push = '{valid: accept, rec: rec};

`ifndef SYNTH
    a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> ((push.rec.rise & push.rec.fall) == '0))
        else $error("rise and fall on the same sensor in one tick");

    a_rise_det: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> ((push.rec.rise & ~push.rec.det) == '0))
        else $error("rising edge without detected level");
`endif

endmodule

// File: design/dbss_fifo.sv
// Short record queue between the front and back parts.
// Depends on dbss_pkg for the record type and depth.

module dbss_fifo
    import dbss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dbss_beat_t push,
    output logic       full,
    output dbss_beat_t pop,
    input  logic       pop_ready
);

    dbss_rec_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop       = '{valid: (count_reg != '0), rec: mem_reg[rd_ptr_reg]};
    assign do_push   = push.valid & ~full;
    assign do_pop    = pop.valid & pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.rec;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// File: design/dbss_back.sv
// Back part: turns queued records into result beats, dividing for speeds.
// Depends on dbss_pkg; reads records from dbss_fifo.

module dbss_back
    import dbss_pkg::*;
#(
    parameter int SENSORS = SENSORS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dbss_beat_t             pop,
    output logic                   pop_ready,
    input  logic [9:0]             box_width_mm,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SENSORS_MAX-1:0] detected,
    output logic [SENSORS_MAX-1:0] rising_pulse,
    output logic [SENSORS_MAX-1:0] falling_pulse,
    output logic [15:0]            speed_0,
    output logic [15:0]            speed_1,
    output logic [15:0]            speed_2,
    output logic [15:0]            speed_3
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_FLUSH = 4'b1000
    } back_state_t;

    back_state_t                  state_reg, state_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [NUM_W-1:0]             num_reg, num_next;
    logic [15:0]                  rem_reg, rem_next;
    logic [15:0]                  den_reg, den_next;
    dbss_rec_t                    wk_reg, wk_next;
    logic [SENSORS_MAX-1:0][15:0] wk_speed_reg, wk_speed_next;
    logic                         out_valid_reg, out_valid_next;
    logic [SENSORS_MAX-1:0]       out_det_reg, out_rise_reg, out_fall_reg;
    logic [SENSORS_MAX-1:0][15:0] out_speed_reg;
    logic                         out_load;
    logic [16:0]                  rem_sh;
    logic [16:0]                  rem_diff;
    logic                         rem_ge;
    logic                         last_idx;

    assign pop_ready = (state_reg == ST_IDLE);
    assign last_idx  = (idx_reg == IDX_W'(SENSORS - 1));

    // one restoring divide step per cycle
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});

    // output register loads when the result beat slot is free
    assign out_load = (state_reg == ST_FLUSH) && (!out_valid_reg || out_ready);

    // sequencer over sensors and divide steps
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        wk_next       = wk_reg;
        wk_speed_next = wk_speed_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop.valid)
                begin
                    wk_next       = pop.rec;
                    wk_speed_next = '0;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (wk_reg.fall[idx_reg] && (wk_reg.ticks[idx_reg] != '0))
                begin
                    num_next   = NUM_W'(box_width_mm) * NUM_W'(MS_PER_S);
                    rem_next   = '0;
                    den_next   = wk_reg.ticks[idx_reg];
                    step_next  = '0;
                    state_next = ST_DIV;
                end
                else if (last_idx)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? rem_diff[15:0] : rem_sh[15:0];
                num_next  = {num_reg[NUM_W-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    // quotient complete, saturate to the speed width
                    wk_speed_next[idx_reg] = (num_next[NUM_W-1:16] != '0) ?
                                             SPEED_MAX : num_next[15:0];
                    step_next = '0;
                    if (last_idx)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        wk_reg       <= wk_next;
        wk_speed_reg <= wk_speed_next;
        if (out_load)
        begin
            out_det_reg   <= wk_reg.det;
            out_rise_reg  <= wk_reg.rise;
            out_fall_reg  <= wk_reg.fall;
            out_speed_reg <= wk_speed_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign detected      = out_det_reg;
    assign rising_pulse  = out_rise_reg;
    assign falling_pulse = out_fall_reg;
    assign speed_0       = out_speed_reg[0];
    assign speed_1       = out_speed_reg[1];
    assign speed_2       = out_speed_reg[2];
    assign speed_3       = out_speed_reg[3];

`ifndef SYNTH
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> (step_reg == '0))
        else $error("divide step count active outside divide");

    a_div_fall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> wk_reg.fall[idx_reg])
        else $error("divide running for a sensor without falling edge");

    a_speed_fall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_fall_reg[0] || (speed_0 == '0)) &&
                           (out_fall_reg[1] || (speed_1 == '0)) &&
                           (out_fall_reg[2] || (speed_2 == '0)) &&
                           (out_fall_reg[3] || (speed_3 == '0))))
        else $error("speed reported without falling edge");
`endif

endmodule

// File: design/debounced_beam_speed_sensor_core.sv
// Top level of the debounced beam speed sensor: configuration registers and
// the front, queue and back parts. Depends on dbss_pkg, dbss_front,
// dbss_fifo and dbss_back.
//
//   channel  direction  handshake              payload
//   tick     in         in_valid / in_ready    pin_levels
//   result   out        out_valid / out_ready  detected, rising_pulse,
//                                              falling_pulse, speed_0..speed_3
//   config   in         cfg_we                 cfg_index, cfg_data
//
// A tick is debounced in the cycle it is accepted; the front takes a new one
// whenever the two-entry queue has room.
// The back scans the sensors of each tick in turn and, for each falling edge
// with a nonzero blocked time, runs the shared one-bit-per-cycle divider.
// The result register lets the back start the next tick while a result waits.
// Reset clears all sensor state and loads debounce 20, box width 100.

module debounced_beam_speed_sensor_core
    import dbss_pkg::*;
#(
    parameter int SENSORS = SENSORS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SENSORS_MAX-1:0] pin_levels,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SENSORS_MAX-1:0] detected,
    output logic [SENSORS_MAX-1:0] rising_pulse,
    output logic [SENSORS_MAX-1:0] falling_pulse,
    output logic [15:0]            speed_0,
    output logic [15:0]            speed_1,
    output logic [15:0]            speed_2,
    output logic [15:0]            speed_3
);

    logic [7:0] deb_reg;
    logic [9:0] box_reg;
    dbss_beat_t push;
    dbss_beat_t pop;
    logic       full;
    logic       pop_ready;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg <= DEB_RESET;
            box_reg <= BOX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: deb_reg <= cfg_data[7:0];
                REG_BOX:      box_reg <= cfg_data[9:0];
                default:      ;
            endcase
        end
    end

    // debounce and edge classification
    dbss_front #(
        .SENSORS (SENSORS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pin_levels     (pin_levels),
        .debounce_ticks (deb_reg),
        .full           (full),
        .push           (push)
    );

    // record queue
    dbss_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    // speed division and result register
    dbss_back #(
        .SENSORS (SENSORS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop           (pop),
        .pop_ready     (pop_ready),
        .box_width_mm  (box_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .detected      (detected),
        .rising_pulse  (rising_pulse),
        .falling_pulse (falling_pulse),
        .speed_0       (speed_0),
        .speed_1       (speed_1),
        .speed_2       (speed_2),
        .speed_3       (speed_3)
    );

endmodule
